// ----- src/recurring_timer_queue_defines.svh -----
// Assertion macros shared by the timer queue checker.
// No dependencies.
`ifndef RECURRING_TIMER_QUEUE_DEFINES_SVH
`define RECURRING_TIMER_QUEUE_DEFINES_SVH
`define RTQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define RTQ_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ----- src/rtq_pkg.sv -----
// Types and constants for the recurring timer queue.
// No dependencies.
package rtq_pkg;
  localparam int SLOTS = 32;
  localparam int MAX_FIRES = 32;
  localparam int SW = $clog2(SLOTS);
  localparam int FW = $clog2(MAX_FIRES + 1);
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    OP_SCHED  = 2'd0,
    OP_FIRE   = 2'd1,
    OP_CANCEL = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_RD, ST_FIRE, ST_EMIT, ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [47:0] now;
    logic [31:0] delay;
    logic signed [15:0] repeat_count;
    logic [15:0] owner;
    logic [15:0] action;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] fired_owner;
    logic [15:0] fired_action;
    logic [47:0] fire_time;
    logic signed [15:0] repeats_left;
    logic [5:0]  cancel_count;
    logic        pending;
    logic        full_error;
    logic        last;
  } out_t;

  // One slot entry as held in the table.
  typedef struct packed {
    logic [47:0] deadline;
    logic [31:0] period;
    logic [15:0] repeats;
    logic [15:0] owner;
    logic [15:0] action;
    logic [15:0] stamp;
  } entry_t;

  function automatic logic [47:0] sat_add(input logic [47:0] t, input logic [31:0] d);
    logic [48:0] s;
    s = {1'b0, t} + {17'd0, d};
    return s[48] ? TIME_MAX : s[47:0];
  endfunction
endpackage

// ----- src/recurring_timer_queue.sv -----
// Recurring timer queue: one item at a time under a scan sequencer.
// Cancel makes one table read per slot through the one memory port.
// Fire sweep: per fired entry a scan through one shared deadline/age compare, a read-back,
// an update and an emit, then a final scan; the next item is taken back in idle.
// Reset (rst, synchronous) clears the state, out_valid, valid bits and the insertion sequence only.
module recurring_timer_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  rtq_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rtq_pkg::out_t  out_data
);
  import rtq_pkg::*;

  state_t state, state_next;
  in_t    req;
  logic [SLOTS-1:0] valid;
  logic [15:0] seq;
  logic [SW:0] idx;
  logic [SW-1:0] best;
  logic        have_best;
  logic [47:0] best_dl;
  logic [15:0] best_age;
  logic [FW-1:0] fires;
  logic [5:0]  ccount;
  logic        rd_pend;
  logic [SW-1:0] rd_idx;

  logic        we;
  logic [SW-1:0] waddr, raddr;
  entry_t      wdata, rdata;

  rtq_table u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Lowest free slot.
  logic [SW-1:0] free_idx;
  logic          free_any;
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = SW'(i);
        free_any = 1'b1;
      end
    end
  end

  // Shared compare unit on the entry just read.
  logic [15:0] age;
  logic        cand, better;
  assign age    = seq - rdata.stamp;
  assign cand   = valid[rd_idx] && rdata.deadline <= req.now;
  assign better = !have_best || rdata.deadline < best_dl ||
                  (rdata.deadline == best_dl && age > best_age);

  // Fired entry update.
  logic [15:0] rnew;
  always_comb begin
    if (rdata.repeats[15]) rnew = 16'hFFFF;
    else if (rdata.repeats > 16'd1) rnew = rdata.repeats - 16'd1;
    else rnew = '0;
  end

  // Result records.
  out_t done_rec, fire_rec;
  always_comb begin
    done_rec = '0;
    done_rec.kind = 1'b1;
    done_rec.last = 1'b1;
    if (state == ST_SCAN) done_rec.cancel_count = ccount;
    if (state == ST_IDLE && op_t'(in_data.opcode) == OP_SCHED) begin
      // a schedule either writes an entry or finds the table full
      done_rec.full_error = !free_any;
      done_rec.pending = 1'b1;
    end else begin
      done_rec.pending = |valid;
    end
    fire_rec = '0;
    fire_rec.fired_owner = rdata.owner;
    fire_rec.fired_action = rdata.action;
    fire_rec.fire_time = rdata.deadline;
    fire_rec.repeats_left = rnew;
    fire_rec.pending = (rnew != '0) || ((valid & ~(SLOTS'(1) << best)) != '0);
  end

  logic scan_end;
  assign scan_end = (idx == (SW+1)'(SLOTS));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) begin
        case (op_t'(in_data.opcode))
          OP_FIRE, OP_CANCEL: state_next = ST_SCAN;
          default: state_next = ST_DONE;
        endcase
      end
      ST_SCAN: if (scan_end && !rd_pend) begin
        if (op_t'(req.opcode) == OP_FIRE && have_best && fires != FW'(MAX_FIRES))
          state_next = ST_RD;
        else
          state_next = ST_DONE;
      end
      ST_RD:   state_next = ST_FIRE;
      ST_FIRE: state_next = ST_EMIT;
      ST_EMIT: if (!out_stall) state_next = ST_SCAN;
      ST_DONE: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    raddr = (state == ST_RD) ? best : idx[SW-1:0];
    we = 1'b0;
    waddr = best;
    wdata = rdata;
    if (state == ST_IDLE && in_valid && op_t'(in_data.opcode) == OP_SCHED && free_any)
    begin
      we = 1'b1;
      waddr = free_idx;
      wdata.period = (in_data.delay == '0) ? 32'd1 : in_data.delay;
      wdata.deadline = sat_add(in_data.now, wdata.period);
      wdata.repeats = in_data.repeat_count[15] ? 16'hFFFF :
                      (in_data.repeat_count == '0 ? 16'd1 : in_data.repeat_count);
      wdata.owner = in_data.owner;
      wdata.action = in_data.action;
      wdata.stamp = seq;
    end else if (state == ST_FIRE && rnew != '0) begin
      we = 1'b1;
      wdata.deadline = sat_add(rdata.deadline, rdata.period);
      wdata.repeats = rnew;
      wdata.stamp = seq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= '0;
      seq <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: if (in_valid) begin
          req <= in_data;
          idx <= '0;
          have_best <= 1'b0;
          rd_pend <= 1'b0;
          fires <= '0;
          ccount <= '0;
          out_data <= done_rec;
          if (op_t'(in_data.opcode) == OP_SCHED && free_any) begin
            valid[free_idx] <= 1'b1;
            seq <= seq + 16'd1;
          end
          if (op_t'(in_data.opcode) == OP_SCHED || op_t'(in_data.opcode) == OP_QUERY)
            out_valid <= 1'b1;
        end
        ST_SCAN: begin
          rd_pend <= !scan_end;
          rd_idx <= idx[SW-1:0];
          if (!scan_end) idx <= idx + (SW+1)'(1);
          if (rd_pend) begin
            if (op_t'(req.opcode) == OP_CANCEL) begin
              if (valid[rd_idx] && rdata.owner == req.owner) begin
                valid[rd_idx] <= 1'b0;
                ccount <= ccount + 6'd1;
              end
            end else if (cand && better) begin
              have_best <= 1'b1;
              best <= rd_idx;
              best_dl <= rdata.deadline;
              best_age <= age;
            end
          end
          if (scan_end && !rd_pend && state_next == ST_DONE) begin
            out_data <= done_rec;
            out_valid <= 1'b1;
          end
        end
        ST_FIRE: begin
          fires <= fires + FW'(1);
          if (rnew != '0) seq <= seq + 16'd1;
          else valid[best] <= 1'b0;
          out_data <= fire_rec;
          out_valid <= 1'b1;
        end
        ST_EMIT: if (!out_stall) begin
          out_valid <= 1'b0;
          idx <= '0;
          have_best <= 1'b0;
          rd_pend <= 1'b0;
        end
        ST_DONE: if (!out_stall) out_valid <= 1'b0;
        default: ;
      endcase
    end
  end
endmodule

// ----- src/rtq_table.sv -----
// Slot table memory of the timer queue: one write and one registered read port.
// Depends on rtq_pkg.
module rtq_table (
  input  logic                clk,
  input  logic                we,
  input  logic [rtq_pkg::SW-1:0] waddr,
  input  rtq_pkg::entry_t     wdata,
  input  logic [rtq_pkg::SW-1:0] raddr,
  output rtq_pkg::entry_t     rdata
);
  import rtq_pkg::*;
  entry_t mem [SLOTS];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- src/rtq_checker.sv -----
// Port-level checker for the recurring timer queue, bound to the top level.
// Depends on rtq_pkg and recurring_timer_queue_defines.svh.
`include "recurring_timer_queue_defines.svh"
module rtq_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input rtq_pkg::out_t out_data
);
  import rtq_pkg::*;
  logic held, taken;
  assign held  = out_valid && out_stall;
  assign taken = in_valid && !in_stall;
  `RTQ_ASSERT(busy_while_out, clk, rst, out_valid |-> in_stall, "input taken during result")
  `RTQ_ASSERT(out_hold, clk, rst, held |=> out_valid && $stable(out_data), "result moved")
  `RTQ_ASSERT(done_last, clk, rst, out_valid |-> out_data.kind == out_data.last, "bad last")
  `RTQ_ASSERT(busy_after_take, clk, rst, taken |=> in_stall, "second beat taken at once")
  `RTQ_ASSERT_RST(rst_clear, clk, rst |=> !out_valid, "result after reset")
endmodule

bind recurring_timer_queue rtq_checker u_rtq_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ----- bench/tb.sv -----
// Self-checking bench for the recurring timer queue: schedule, sweep, cancel, query.
// Depends on rtq_pkg and recurring_timer_queue; carries its own timer-table model.
`timescale 1ns / 100ps

module tb;
  import rtq_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  always #5 clk = ~clk;

  recurring_timer_queue i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Timer table model
  logic        tq_used [SLOTS];
  logic [47:0] tq_deadline [SLOTS];
  logic [31:0] tq_period [SLOTS];
  logic [15:0] tq_repeats [SLOTS];
  logic [15:0] tq_owner [SLOTS];
  logic [15:0] tq_action [SLOTS];
  logic [15:0] tq_stamp [SLOTS];
  logic [15:0] tq_seq;

  out_t expected_beats[$];
  int   error_count = 0;
  int   fired_seen = 0;
  int   items_sent = 0;
  int   full_seen = 0;
  bit   sender_active = 1'b1;
  int   gap_max = 4;

  function automatic logic tq_any();
    logic a;
    a = 1'b0;
    for (int i = 0; i < SLOTS; i++) a |= tq_used[i];
    return a;
  endfunction

  function automatic logic [47:0] tq_sat(input logic [47:0] t, input logic [31:0] d);
    logic [48:0] s;
    s = {1'b0, t} + {17'd0, d};
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

  function automatic out_t done_beat(input logic [5:0] cnt, input logic full);
    out_t r;
    r = '0;
    r.kind = 1'b1;
    r.cancel_count = cnt;
    r.full_error = full;
    r.pending = tq_any();
    r.last = 1'b1;
    return r;
  endfunction

  function automatic int tq_used_count();
    int c;
    c = 0;
    for (int i = 0; i < SLOTS; i++) c += tq_used[i];
    return c;
  endfunction

  // Append one expected beat.
  function automatic void queue_beat(input out_t b);
    expected_beats = {expected_beats, b};
  endfunction

  // Apply one item to the model and queue the beats it produces.
  function automatic void predict_timer_op(input in_t it);
    int slot, best;
    logic [15:0] age, best_age, r, d16;
    logic [31:0] dly;
    logic [47:0] t;
    logic [5:0] cnt;
    out_t o;
    case (op_t'(it.opcode))
      OP_SCHED: begin
        slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--) if (!tq_used[i]) slot = i;
        if (slot < 0) begin
          queue_beat(done_beat('0, 1'b1));
        end else begin
          dly = (it.delay == 0) ? 32'd1 : it.delay;
          d16 = it.repeat_count;
          if (d16[15]) d16 = 16'hFFFF;
          else if (d16 == 0) d16 = 16'd1;
          tq_used[slot] = 1'b1;
          tq_deadline[slot] = tq_sat(it.now, dly);
          tq_period[slot] = dly;
          tq_repeats[slot] = d16;
          tq_owner[slot] = it.owner;
          tq_action[slot] = it.action;
          tq_stamp[slot] = tq_seq;
          tq_seq++;
          queue_beat(done_beat('0, 1'b0));
        end
      end
      OP_FIRE: begin
        for (int f = 0; f < MAX_FIRES; f++) begin
          best = -1;
          best_age = '0;
          for (int i = 0; i < SLOTS; i++) begin
            if (!tq_used[i] || tq_deadline[i] > it.now) continue;
            age = tq_seq - tq_stamp[i];
            if (best < 0 || tq_deadline[i] < tq_deadline[best] ||
                (tq_deadline[i] == tq_deadline[best] && age > best_age)) begin
              best = i;
              best_age = age;
            end
          end
          if (best < 0) break;
          t = tq_deadline[best];
          r = tq_repeats[best];
          if (r[15]) r = 16'hFFFF;
          else if (r > 1) r = r - 16'd1;
          else r = '0;
          if (r != 0) begin
            tq_deadline[best] = tq_sat(t, tq_period[best]);
            tq_repeats[best] = r;
            tq_stamp[best] = tq_seq;
            tq_seq++;
          end else begin
            tq_used[best] = 1'b0;
          end
          o = '0;
          o.fired_owner = tq_owner[best];
          o.fired_action = tq_action[best];
          o.fire_time = t;
          o.repeats_left = r;
          o.pending = tq_any();
          queue_beat(o);
        end
        queue_beat(done_beat('0, 1'b0));
      end
      OP_CANCEL: begin
        cnt = '0;
        for (int i = 0; i < SLOTS; i++)
          if (tq_used[i] && tq_owner[i] == it.owner) begin
            tq_used[i] = 1'b0;
            cnt++;
          end
        queue_beat(done_beat(cnt, 1'b0));
      end
      default: queue_beat(done_beat('0, 1'b0));
    endcase
  endfunction

  // Send one beat; the sender idles in bursts with random gaps.
  task automatic send_timer_op(input in_t it);
    int gap;
    gap = (gap_max > 0 && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, gap_max)) : 0;
    // the release of the last beat is always seen before this one is raised
    repeat (gap + 1) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_timer_op(it);
    items_sent++;
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  function automatic in_t make_op(input op_t op, input logic [47:0] now_t,
                                  input logic [31:0] dly, input logic [15:0] rep,
                                  input logic [15:0] own, input logic [15:0] act);
    in_t it;
    it.opcode = op;
    it.now = now_t;
    it.delay = dly;
    it.repeat_count = rep;
    it.owner = own;
    it.action = act;
    return it;
  endfunction

  // Current simulated time base for well-formed sequences
  logic [47:0] clock_now = 48'd0;

  task automatic test_basic_ops();
    send_timer_op(make_op(OP_QUERY, 48'd0, 32'd0, 16'd0, 16'd0, 16'd0));
    send_timer_op(make_op(OP_FIRE, 48'd0, 32'd0, 16'd0, 16'd0, 16'd0));
    send_timer_op(make_op(OP_SCHED, 48'd100, 32'd0, 16'd0, 16'h0001, 16'hFFFF));
    send_timer_op(make_op(OP_SCHED, 48'd100, 32'd1, 16'h7FFF, 16'hFFFF, 16'h0000));
    send_timer_op(make_op(OP_SCHED, 48'd50, 32'd51, 16'h8000, 16'h0002, 16'h1234));
    send_timer_op(make_op(OP_SCHED, 48'd0, 32'd3, 16'hFFFF, 16'h0002, 16'h5678));
    send_timer_op(make_op(OP_QUERY, 48'd0, 32'd0, 16'd0, 16'd0, 16'd0));
    // ties at deadline 101, repeating entries re-fire within one sweep
    send_timer_op(make_op(OP_FIRE, 48'd110, 32'd0, 16'd0, 16'd0, 16'd0));
    send_timer_op(make_op(OP_CANCEL, 48'd0, 32'd0, 16'd0, 16'h0002, 16'd0));
    send_timer_op(make_op(OP_CANCEL, 48'd0, 32'd0, 16'd0, 16'h0002, 16'd0));
    send_timer_op(make_op(OP_CANCEL, 48'd0, 32'd0, 16'd0, 16'hFFFF, 16'd0));
    send_timer_op(make_op(OP_FIRE, 48'hFFFF_FFFF_FFFF, 32'd0, 16'd0, 16'd0, 16'd0));
    wait_drained();
  endtask

  task automatic test_saturation();
    send_timer_op(make_op(OP_SCHED, 48'hFFFF_FFFF_FFF0, 32'hFFFF_FFFF, 16'd3,
                          16'h0003, 16'hAAAA));
    send_timer_op(make_op(OP_SCHED, 48'hFFFF_FFFF_FFFE, 32'd1, 16'hFFFF,
                          16'h0003, 16'h5555));
    send_timer_op(make_op(OP_FIRE, 48'hFFFF_FFFF_FFFF, 32'd0, 16'd0, 16'd0, 16'd0));
    send_timer_op(make_op(OP_CANCEL, 48'd0, 32'd0, 16'd0, 16'h0003, 16'd0));
    wait_drained();
  endtask

  task automatic test_full_table();
    for (int i = 0; i < SLOTS + 2; i++)
      send_timer_op(make_op(OP_SCHED, 48'd1000, 32'd10 + i[31:0], 16'd1,
                            16'h0004, i[15:0]));
    send_timer_op(make_op(OP_FIRE, 48'd5000, 32'd0, 16'd0, 16'd0, 16'd0));
    for (int i = 0; i < SLOTS; i++)
      send_timer_op(make_op(OP_SCHED, 48'd0, 32'd5, 16'hFFFF, 16'h0005, i[15:0]));
    // forever entries due many times: sweep hits the fire limit
    send_timer_op(make_op(OP_FIRE, 48'd100, 32'd0, 16'd0, 16'd0, 16'd0));
    send_timer_op(make_op(OP_CANCEL, 48'd0, 32'd0, 16'd0, 16'h0005, 16'd0));
    wait_drained();
  endtask

  task automatic test_random_traffic(input int count);
    in_t it;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      it = in_t'({$urandom, $urandom, $urandom, $urandom, 2'($urandom)});
      if (pick < 45) begin
        it.opcode = OP_SCHED;
        it.now = clock_now;
        if ($urandom_range(0, 9) != 0) it.delay = $urandom_range(0, 400);
        if ($urandom_range(0, 3) != 0) it.repeat_count = 16'($urandom_range(0, 6));
        it.owner = 16'($urandom_range(0, 7));
        if ($urandom_range(0, 19) == 0) it.owner = 16'($urandom);
        if (tq_used_count() >= SLOTS - 2 && $urandom_range(0, 3) != 0)
          it.opcode = OP_CANCEL;
      end else if (pick < 80) begin
        it.opcode = OP_FIRE;
        clock_now = clock_now + $urandom_range(0, 300);
        it.now = ($urandom_range(0, 29) == 0) ? it.now : clock_now;
      end else if (pick < 92) begin
        it.opcode = OP_CANCEL;
        it.owner = 16'($urandom_range(0, 7));
      end else begin
        it.opcode = OP_QUERY;
      end
      send_timer_op(it);
      if (n == count / 2) begin
        // hold off until the block has delivered everything
        while (expected_beats.size() != 0) @(posedge clk);
        gap_max = (gap_max == 0) ? 6 : 0;
      end
    end
  endtask

  // Receiver stall pattern: alternating phases of free flow and random stalls.
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[9]) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // Result checker
  always @(posedge clk) begin
    out_t exp_beat;
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, out_data);
        error_count++;
      end else begin
        exp_beat = expected_beats.pop_front();
        if (out_data !== exp_beat) begin
          $display("%0t: expected k=%0d o=%h a=%h t=%h r=%0d c=%0d p=%0d f=%0d l=%0d",
                   $time, exp_beat.kind, exp_beat.fired_owner, exp_beat.fired_action,
                   exp_beat.fire_time, exp_beat.repeats_left, exp_beat.cancel_count,
                   exp_beat.pending, exp_beat.full_error, exp_beat.last);
          $display("%0t: actual   k=%0d o=%h a=%h t=%h r=%0d c=%0d p=%0d f=%0d l=%0d",
                   $time, out_data.kind, out_data.fired_owner, out_data.fired_action,
                   out_data.fire_time, out_data.repeats_left, out_data.cancel_count,
                   out_data.pending, out_data.full_error, out_data.last);
          error_count++;
        end
        if (exp_beat.kind == 1'b0) fired_seen++;
        if (exp_beat.full_error) full_seen++;
      end
    end
  end

  // Watchdog on cycles with no accepted beat
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) tq_used[i] = 1'b0;
    tq_seq = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_ops();
    test_saturation();
    test_full_table();
    test_random_traffic(245);
    wait_drained();
    $display("Covered %0d items, %0d entry firings, %0d full-table rejects.",
             items_sent, fired_seen, full_seen);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+src
src/rtq_pkg.sv
src/rtq_table.sv
src/recurring_timer_queue.sv
src/rtq_checker.sv
bench/tb.sv
